/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, disabled while rst is true.
`define ASSERT_HOLDS(name, clk, rst, prop, msg) \
    name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent property that is checked at every edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bpd_pkg.sv */
// ----------------------------------------------------------------------------
// bpd_pkg
// Types and constants of the bitmap pixel array decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_IDX_W     = $clog2(PALETTE_DEPTH);
    localparam int COLOR_W       = 24;
    localparam int POS_W         = 12;
    localparam int DIM_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        KIND_PALETTE = 2'd0,
        KIND_PIXEL   = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FMT_4BIT  = 2'd0,
        FMT_8BIT  = 2'd1,
        FMT_24BIT = 2'd2,
        FMT_NONE  = 2'd3
    } format_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
        logic [7:0]  data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       image_end;
        logic       burst_end;
    } out_word_t;

    // One queued job: a palette write or the pixels that one byte completes.
    typedef struct packed {
        logic                 op_write;
        logic                 two_pix;
        logic                 direct;
        logic [PAL_IDX_W-1:0] idx0;
        logic [PAL_IDX_W-1:0] idx1;
        logic [COLOR_W-1:0]   color;
        logic                 rend0;
        logic                 iend0;
        logic                 rend1;
        logic                 iend1;
    } job_t;

endpackage

`default_nettype wire

/* hdl/bpd_front.sv */
// ----------------------------------------------------------------------------
// bpd_front
// Configuration registers, byte classification and frame position tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_front import bpd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    input  wire logic                  q_full,
    output logic                       push_valid,
    output job_t                       push_job
);

    format_t            fmt_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    logic [POS_W-1:0]   col_reg,     col_next;
    logic [POS_W-1:0]   row_reg,     row_next;
    logic [1:0]         phase_reg,   phase_next;
    logic [15:0]        partial_reg, partial_next;
    logic [1:0]         pad_reg,     pad_next;

    logic [DIM_W-1:0]   eff_w, eff_h, w_plus1;
    logic [DIM_W-1:0]   col1, col2, row1;
    logic [1:0]         row_bytes_lo, pad_calc;
    logic               rend0, iend0, rend1, iend1, row_last;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= FMT_24BIT;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FORMAT: fmt_reg    <= format_t'(cfg_data[1:0]);
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (width_reg == '0)         eff_w = DIM_W'(1);
        else if (width_reg > WIDTH_LIMIT)     eff_w = WIDTH_LIMIT;
        else                                  eff_w = width_reg;
        priority if (height_reg == '0)        eff_h = DIM_W'(1);
        else if (height_reg > HEIGHT_LIMIT)   eff_h = HEIGHT_LIMIT;
        else                                  eff_h = height_reg;

        w_plus1 = eff_w + DIM_W'(1);
        unique case (fmt_reg)
            FMT_4BIT: row_bytes_lo = w_plus1[2:1];
            FMT_8BIT: row_bytes_lo = eff_w[1:0];
            default:  row_bytes_lo = 2'(eff_w[1:0] + {eff_w[0], 1'b0});
        endcase
        pad_calc = 2'(2'd0 - row_bytes_lo);

        col1     = {1'b0, col_reg} + DIM_W'(1);
        col2     = col1 + DIM_W'(1);
        row1     = {1'b0, row_reg} + DIM_W'(1);
        row_last = (row1 >= eff_h);
        rend0    = (col1 >= eff_w);
        iend0    = rend0 && row_last;
        rend1    = (col2 >= eff_w);
        iend1    = rend1 && row_last;
    end

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        pad_next     = pad_reg;
        push_valid   = 1'b0;

        push_job          = '0;
        push_job.idx0     = s_data.palette_index;
        push_job.color    = s_data.palette_color;
        push_job.rend0    = rend0;
        push_job.iend0    = iend0;
        push_job.rend1    = rend1;
        push_job.iend1    = iend1;

        if (accept) begin
            unique case (kind_t'(s_data.kind))
                KIND_PALETTE: begin
                    push_valid        = 1'b1;
                    push_job.op_write = 1'b1;
                end
                KIND_RESTART: begin
                    col_next     = '0;
                    row_next     = '0;
                    phase_next   = '0;
                    partial_next = '0;
                    pad_next     = '0;
                end
                KIND_PIXEL: begin
                    priority if (fmt_reg == FMT_NONE) begin
                    end else if (pad_reg != 2'd0) begin
                        pad_next = 2'(pad_reg - 2'd1);
                    end else if (fmt_reg == FMT_4BIT) begin
                        push_valid    = 1'b1;
                        push_job.idx0 = PAL_IDX_W'(s_data.data_byte[7:4]);
                        push_job.idx1 = PAL_IDX_W'(s_data.data_byte[3:0]);
                        if (rend0) begin
                            pad_next     = pad_calc;
                            col_next     = '0;
                            phase_next   = '0;
                            partial_next = '0;
                            row_next     = iend0 ? '0 : row1[POS_W-1:0];
                        end else begin
                            push_job.two_pix = 1'b1;
                            if (rend1) begin
                                pad_next     = pad_calc;
                                col_next     = '0;
                                phase_next   = '0;
                                partial_next = '0;
                                row_next     = iend1 ? '0 : row1[POS_W-1:0];
                            end else begin
                                col_next = col2[POS_W-1:0];
                            end
                        end
                    end else if (fmt_reg == FMT_8BIT || phase_reg == 2'd2) begin
                        push_valid      = 1'b1;
                        push_job.idx0   = PAL_IDX_W'(s_data.data_byte);
                        push_job.direct = (fmt_reg != FMT_8BIT);
                        push_job.color  = {s_data.data_byte, partial_reg};
                        phase_next      = (fmt_reg != FMT_8BIT) ? 2'd0 : phase_reg;
                        partial_next    = (fmt_reg != FMT_8BIT) ? '0 : partial_reg;
                        if (rend0) begin
                            pad_next     = pad_calc;
                            col_next     = '0;
                            phase_next   = '0;
                            partial_next = '0;
                            row_next     = iend0 ? '0 : row1[POS_W-1:0];
                        end else begin
                            col_next = col1[POS_W-1:0];
                        end
                    end else if (phase_reg == 2'd1) begin
                        partial_next = {s_data.data_byte, partial_reg[7:0]};
                        phase_next   = 2'd2;
                    end else begin
                        partial_next = {8'd0, s_data.data_byte};
                        phase_next   = 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            partial_reg <= '0;
            pad_reg     <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            pad_reg     <= pad_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/bpd_queue.sv */
// ----------------------------------------------------------------------------
// bpd_queue
// Short job queue between the classifier and the palette lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_queue import bpd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    input  wire job_t push_job,
    output logic      q_full,
    output logic      head_valid,
    output job_t      head_job,
    input  wire logic pop
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              do_push, do_pop;

    assign q_full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !q_full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/bpd_back.sv */
// ----------------------------------------------------------------------------
// bpd_back
// Palette memory, lookup and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_back import bpd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic head_valid,
    input  wire job_t head_job,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_word_t m_data
);

    logic [COLOR_W-1:0]   palette_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0]   rd_data_reg;

    logic                 second_reg, second_next;
    logic                 b_valid_reg, b_valid_next;
    logic                 b_direct_reg;
    logic [COLOR_W-1:0]   b_color_reg;
    logic                 b_rend_reg, b_iend_reg, b_burst_reg;

    logic                 advance, issue, do_write, do_pixel;
    logic [PAL_IDX_W-1:0] rd_addr;
    logic [COLOR_W-1:0]   color;

    assign advance  = !b_valid_reg || m_ready;
    assign issue    = head_valid && advance;
    assign do_write = issue && head_job.op_write;
    assign do_pixel = issue && !head_job.op_write;
    assign rd_addr  = second_reg ? head_job.idx1 : head_job.idx0;
    assign pop      = do_write || (do_pixel && (!head_job.two_pix || second_reg));

    always_comb begin
        second_next  = do_pixel ? (head_job.two_pix && !second_reg) : second_reg;
        b_valid_next = advance ? do_pixel : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            palette_mem[head_job.idx0] <= head_job.color;
        end
        if (do_pixel) begin
            rd_data_reg <= palette_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pixel) begin
            b_direct_reg <= head_job.direct;
            b_color_reg  <= head_job.color;
            b_rend_reg   <= second_reg ? head_job.rend1 : head_job.rend0;
            b_iend_reg   <= second_reg ? head_job.iend1 : head_job.iend0;
            b_burst_reg  <= !head_job.two_pix || second_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            second_reg  <= second_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_comb begin
        color            = b_direct_reg ? b_color_reg : rd_data_reg;
        m_valid          = b_valid_reg;
        m_data.red       = color[23:16];
        m_data.green     = color[15:8];
        m_data.blue      = color[7:0];
        m_data.row_end   = b_rend_reg;
        m_data.image_end = b_iend_reg;
        m_data.burst_end = b_burst_reg;
    end

endmodule

`default_nettype wire

/* hdl/bmp_pixel_array_decoder_core.sv */
// ----------------------------------------------------------------------------
// bmp_pixel_array_decoder_core
// Uncompressed bitmap pixel array decoder, one byte word in, RGB pixels out.
// ----------------------------------------------------------------------------
// Input words (s_) carry a palette write, a pixel array byte or a frame
// restart. Result words (m_) carry one RGB pixel with row, image and burst
// end marks. Registers (format, width, height) are written on the cfg_
// channel, which is always ready; write them only while the block is idle.
// A pixel's last byte passes the job queue and output register to m_valid.
// One input word is taken per cycle while the queue has room; a 4-bit byte
// that yields two pixels makes two palette lookups in turn, since the palette
// memory has a single read port. The four-entry job queue lets input continue
// while the output is stalled; when it fills, s_ready drops until m_ready
// drains it. Reset clears position state, the queue and the output register;
// the palette memory keeps no reset value and must be written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_array_decoder_core import bpd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data
);

    logic q_full, push_valid, head_valid, pop;
    job_t push_job, head_job;

    bpd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    bpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .q_full     (q_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    bpd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

/* hdl/bpd_checker.sv */
// ----------------------------------------------------------------------------
// bpd_checker
// Port level checks of the decoder core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpd_checker import bpd_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    `ASSERT_HOLDS(a_out_hold, aclk, !aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled word changed")

    `ASSERT_HOLDS(a_image_end_row, aclk, !aresetn, m_valid |-> (!m_data.image_end || m_data.row_end), "image end without row end")

    `ASSERT_HOLDS(a_row_end_burst, aclk, !aresetn, m_valid && m_data.row_end |-> m_data.burst_end, "pixel after row end in one burst")

    `ASSERT_HOLDS(a_burst_follows, aclk, !aresetn, m_valid && m_ready && !m_data.burst_end |=> m_valid, "burst broken")

endmodule

bind bmp_pixel_array_decoder_core bpd_checker u_checker (.*);

`default_nettype wire
